>>> src/sliding_window_maximum_core_defines.svh
// Assertion macros shared by the sliding window maximum checker.
`ifndef SLIDING_WINDOW_MAXIMUM_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define SWM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define SWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/swm_pkg.sv
// Shared types and constants of the sliding window maximum core.
package swm_pkg;

	localparam int DATA_W = 32;
	localparam int CFG_W  = 7;

	// One deque slot: a kept flag and the sample it holds
	typedef struct packed {
		logic                     kept;
		logic signed [DATA_W-1:0] value;
	} entry_t;

endpackage

>>> src/sliding_window_maximum_core.sv
// Sliding window maximum core top level. The block accepts one signed sample per clock while
// not stalled and, once window_length samples of the current sequence have arrived, returns the
// maximum of the last window_length samples for every further sample. Samples travel down a
// row of MAX_WINDOW cells, one cell per accepted sample; each cell keeps its sample only while
// it is inside the window and no newer sample is strictly larger, so the kept cells form the
// monotonic deque and the oldest kept cell is the result. A registered selection tree of
// ceil(log2(MAX_WINDOW)) levels finds that cell; a result passes the pending register and then
// each tree level before it shows on m_tvalid. The sustained rate is one sample per cycle; input
// stalls only when the pending flag and every tree stage are full and the output is held.
// A set tuser bit starts a new sequence. The window length register may only be written
// while the core is idle; zero acts as one and values above MAX_WINDOW act as MAX_WINDOW.
module sliding_window_maximum_core
	import swm_pkg::*;
#(
	parameter int MAX_WINDOW = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	// input samples
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic signed [DATA_W-1:0] s_tdata,   // [31:0] sample
	input  logic [0:0]               s_tuser,   // [0] start_of_sequence
	// results
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic signed [DATA_W-1:0] m_tdata,   // [31:0] window_max
	// window length register
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_W-1:0]         cfg_data
);

	localparam int K_W   = $clog2(MAX_WINDOW + 1);
	localparam int CMP_W = (K_W > CFG_W) ? K_W : CFG_W;

	logic [CFG_W-1:0] window_length_q;
	logic [CMP_W-1:0] len_x;
	logic [K_W-1:0]   k;
	logic [K_W-1:0]   fill_q;
	logic [K_W-1:0]   fill_nx;
	logic             pend_q;
	logic             accept;
	logic             start;
	logic             produce;
	logic             tree_ready;
	entry_t           left_w [MAX_WINDOW];
	entry_t           cell_w [MAX_WINDOW];

	// window length register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= CFG_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			window_length_q <= cfg_data;
		end
	end

	// effective window, clamped to 1..MAX_WINDOW
	assign len_x = CMP_W'(window_length_q);

	always_comb begin
		if (len_x == '0) begin
			k = K_W'(1);
		end else if (len_x > CMP_W'(MAX_WINDOW)) begin
			k = K_W'(MAX_WINDOW);
		end else begin
			k = K_W'(len_x);
		end
	end

	// request handshake; the pending flag marks a result waiting to enter the tree
	assign s_tready = !pend_q || tree_ready;
	assign accept   = s_tvalid && s_tready;
	assign start    = s_tuser[0];

	// fill count, saturating at MAX_WINDOW
	always_comb begin
		if (start) begin
			fill_nx = K_W'(1);
		end else if (fill_q == K_W'(MAX_WINDOW)) begin
			fill_nx = fill_q;
		end else begin
			fill_nx = fill_q + K_W'(1);
		end
	end

	assign produce = (fill_nx >= k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			pend_q <= 1'b0;
		end else if (s_tready) begin
			pend_q <= accept && produce;
			if (accept) begin
				fill_q <= fill_nx;
			end
		end
	end

	// cell row: the new sample enters cell 0; a start flag empties the rest
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_w[i] = '{kept: 1'b1, value: s_tdata};
		end else begin : g_body
			assign left_w[i] = '{kept: cell_w[i-1].kept && !start, value: cell_w[i-1].value};
		end

		swm_cell #(
			.AGE (i),
			.K_W (K_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (accept),
			.k      (k),
			.sample (s_tdata),
			.left   (left_w[i]),
			.slot   (cell_w[i])
		);
	end

	// oldest kept cell is the window maximum
	swm_pick_tree #(
		.N (MAX_WINDOW)
	) u_tree (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pend_q),
		.in_ready  (tree_ready),
		.leaves    (cell_w),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (m_tdata)
	);

endmodule

>>> src/swm_cell.sv
// One cell of the sample chain: holds the sample of one fixed age and its kept flag.
module swm_cell
	import swm_pkg::*;
#(
	parameter int AGE = 0,
	parameter int K_W = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic [K_W-1:0]           k,
	input  logic signed [DATA_W-1:0] sample,
	input  entry_t                   left,
	output entry_t                   slot
);

	logic   kept_q;
	logic   signed [DATA_W-1:0] value_q;
	logic   keep_nx;

	// survives if still inside the window and not beaten by the new sample
	assign keep_nx = left.kept && (K_W'(AGE) < k) && !($signed(left.value) < sample);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= 1'b0;
		end else if (en) begin
			kept_q <= keep_nx;
		end
	end

	// sample moves one cell further every accepted request
	always_ff @(posedge clk) begin
		if (en) begin
			value_q <= left.value;
		end
	end

	assign slot.kept  = kept_q;
	assign slot.value = value_q;

endmodule

>>> src/swm_pick_tree.sv
// Registered selection tree: picks the oldest kept cell, one tree level per stage.
module swm_pick_tree
	import swm_pkg::*;
#(
	parameter int N = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  entry_t                   leaves [N],
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] out_value
);

	localparam int L = $clog2(N);
	localparam int P = 1 << L;

	entry_t leaf_w [P];
	entry_t node_q [1:P-1];
	logic   [L:1]   v_q;
	logic   [L+1:1] en;

	// pad the leaf row up to a power of two with empty slots
	for (genvar i = 0; i < P; i++) begin : g_leaf
		if (i < N) begin : g_real
			assign leaf_w[i] = leaves[i];
		end else begin : g_pad
			assign leaf_w[i] = '{kept: 1'b0, value: '0};
		end
	end

	// stall chain: a stage moves when empty or when the next one moves
	assign en[L+1] = out_ready;
	for (genvar l = 1; l <= L; l++) begin : g_en
		assign en[l] = !v_q[l] || en[l+1];
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[1]) begin
				v_q[1] <= in_valid;
			end
			for (int l = 2; l <= L; l++) begin
				if (en[l]) begin
					v_q[l] <= v_q[l-1];
				end
			end
		end
	end

	// tree nodes in heap order; the higher child holds older samples
	for (genvar j = 1; j < P; j++) begin : g_node
		localparam int LV = L - ($clog2(j + 1) - 1);
		entry_t lo, hi;
		if (2 * j >= P) begin : g_from_leaf
			assign lo = leaf_w[2*j-P];
			assign hi = leaf_w[2*j+1-P];
		end else begin : g_from_node
			assign lo = node_q[2*j];
			assign hi = node_q[2*j+1];
		end
		always_ff @(posedge clk) begin
			if (en[LV]) begin
				node_q[j].kept  <= hi.kept || lo.kept;
				node_q[j].value <= hi.kept ? hi.value : lo.value;
			end
		end
	end

	assign in_ready  = en[1];
	assign out_valid = v_q[L];
	assign out_value = node_q[1].value;

endmodule

>>> src/swm_checker.sv
// Port-level assertions for the sliding window maximum core, bound to the top level.
`include "sliding_window_maximum_core_defines.svh"

module swm_checker
	import swm_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tready,
	input  logic                     m_tvalid,
	input  logic                     m_tready,
	input  logic signed [DATA_W-1:0] m_tdata,
	input  logic                     cfg_valid,
	input  logic                     cfg_ready
);

	// register writes are never refused
	`SWM_ASSERT_IMPL(a_cfg_taken, clk, arst_n, cfg_valid, cfg_ready, "config write refused")

	// input backpressure only comes from a held result
	`SWM_ASSERT_IMPL(a_stall_cause, clk, arst_n, !s_tready, m_tvalid && !m_tready, "input stalled without a held result")

	// a held result stays put
	`SWM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "held result changed")

endmodule

bind sliding_window_maximum_core swm_checker u_swm_checker (.*);
